### rtl/lcbl_pkg.sv
`default_nettype none

package lcbl_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 31;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INTERVAL_MS  = 3'd0,
      CSR_LOW_DIFF     = 3'd1,
      CSR_HIGH_DIFF    = 3'd2,
      CSR_DRIVE_MAX    = 3'd3,
      CSR_DRIVE_START  = 3'd4,
      CSR_SKIP_CHECKS  = 3'd5,
      CSR_FINAL_CHECKS = 3'd6
   } csr_index_type;

   localparam logic [15:0] INTERVAL_MS_RST  = 16'd100;
   localparam logic [30:0] LOW_DIFF_RST     = 31'd2560;
   localparam logic [30:0] HIGH_DIFF_RST    = 31'd12800;
   localparam logic [7:0]  DRIVE_MAX_RST    = 8'd255;
   localparam logic [7:0]  DRIVE_START_RST  = 8'd32;
   localparam logic [6:0]  SKIP_CHECKS_RST  = 7'd20;
   localparam logic [6:0]  FINAL_CHECKS_RST = 7'd50;
   localparam logic [6:0]  CHECK_COUNT_MAX  = 7'd127;

   typedef struct packed {
      logic [15:0] interval_ms;
      logic [30:0] low_diff;
      logic [30:0] high_diff;
      logic [7:0]  drive_max;
      logic [6:0]  skip_checks;
      logic [6:0]  final_checks;
   } cfg_type;

   typedef struct packed {
      logic        [31:0] now_ms;
      logic signed [31:0] red_level;
      logic signed [31:0] ir_level;
   } req_type;

   typedef struct packed {
      logic [7:0] drive_code;
      logic       drive_changed;
      logic       is_calibrated;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/lcbl_csr.sv
`default_nettype none

module lcbl_csr
   import lcbl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_ms  <= INTERVAL_MS_RST;
         cfg_ff.low_diff     <= LOW_DIFF_RST;
         cfg_ff.high_diff    <= HIGH_DIFF_RST;
         cfg_ff.drive_max    <= DRIVE_MAX_RST;
         cfg_ff.skip_checks  <= SKIP_CHECKS_RST;
         cfg_ff.final_checks <= FINAL_CHECKS_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_INTERVAL_MS:  cfg_ff.interval_ms  <= csr_wdata[15:0];
            CSR_LOW_DIFF:     cfg_ff.low_diff     <= csr_wdata[30:0];
            CSR_HIGH_DIFF:    cfg_ff.high_diff    <= csr_wdata[30:0];
            CSR_DRIVE_MAX:    cfg_ff.drive_max    <= csr_wdata[7:0];
            // start code only matters at reset, which restores its reset value
            CSR_DRIVE_START:  ;
            CSR_SKIP_CHECKS:  cfg_ff.skip_checks  <= csr_wdata[6:0];
            CSR_FINAL_CHECKS: cfg_ff.final_checks <= csr_wdata[6:0];
            default:          ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/lcbl_core.sv
`default_nettype none

module lcbl_core
   import lcbl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire cfg_type cfg,
   input  wire req_type item,
   output rsp_type      result
);

   logic [7:0]  drive_ff, drive_in;
   logic [6:0]  count_ff, count_in;
   logic [31:0] last_ff,  last_in;
   logic        done_ff,  done_in;

   logic [31:0] elapsed;
   logic        due;
   logic [32:0] diff;
   logic [31:0] mag;
   logic        below_low;
   logic        above_high;
   logic        changed;
   logic [6:0]  count_inc;

   always_comb begin
      elapsed    = item.now_ms - last_ff;
      due        = !done_ff && (elapsed >= {16'd0, cfg.interval_ms});
      diff       = {item.ir_level[31], item.ir_level} - {item.red_level[31], item.red_level};
      mag        = diff[32] ? 32'(-diff) : diff[31:0];
      below_low  = mag < {1'b0, cfg.low_diff};
      above_high = mag > {1'b0, cfg.high_diff};
      count_inc  = (count_ff < CHECK_COUNT_MAX) ? count_ff + 7'd1 : count_ff;

      drive_in = drive_ff;
      count_in = count_ff;
      changed  = 1'b0;
      if (due) begin
         if (count_ff <= cfg.skip_checks) begin
            count_in = count_inc;
         end else if (below_low && drive_ff != 8'd0) begin
            drive_in = drive_ff - 8'd1;
            changed  = 1'b1;
         end else if (above_high && drive_ff < cfg.drive_max) begin
            drive_in = drive_ff + 8'd1;
            changed  = 1'b1;
         end else begin
            count_in = count_inc;
         end
      end
      done_in = done_ff || (due && count_in == cfg.final_checks);
      last_in = due ? item.now_ms : last_ff;

      result.drive_code    = drive_in;
      result.drive_changed = changed;
      result.is_calibrated = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= DRIVE_START_RST;
         count_ff <= 7'd0;
         last_ff  <= 32'd0;
         done_ff  <= 1'b0;
      end else if (fire) begin
         drive_ff <= drive_in;
         count_ff <= count_in;
         last_ff  <= last_in;
         done_ff  <= done_in;
      end
   end

endmodule

`default_nettype wire

### rtl/led_current_balance_loop_unit.sv
// channel | ports               | payload
// --------+---------------------+-------------------------------------------
// input   | req_valid/req_ready | req_data: now_ms, red_level, ir_level
// result  | rsp_valid/rsp_ready | rsp_data: drive_code, drive_changed, is_calibrated
// config  | csr_wr_en           | csr_index, csr_wdata (write only)
//
// One item per cycle sustained while rsp_ready holds; an accepted item passes the input and result registers.
// An input register feeds the balance logic, which writes the result register
// and the loop state in the same cycle, so the next item sees the updated state.
// Synchronous reset returns the loop state to its start values and clears the valid flags, no clearing pass.
// A stalled result holds the result register; one more item waits in the
// input register before req_ready drops.
`default_nettype none

module led_current_balance_loop_unit
   import lcbl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   req_type item_ff;
   logic    item_vld_ff;
   rsp_type res_ff;
   rsp_type res_in;
   logic    res_vld_ff;
   logic    fire;

   assign fire      = item_vld_ff && (!res_vld_ff || rsp_ready);
   assign req_ready = !item_vld_ff || fire;
   assign rsp_valid = res_vld_ff;
   assign rsp_data  = res_ff;

   lcbl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcbl_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .cfg    (cfg),
      .item   (item_ff),
      .result (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         res_vld_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            item_vld_ff <= req_valid;
         end
         if (fire) begin
            res_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            res_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      if (fire) begin
         res_ff <= res_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_fire_loads_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> res_vld_ff)
      else $error("result register not valid after an item was processed");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (item_vld_ff && res_vld_ff && !rsp_ready))
      else $error("input stalled while the pipeline could advance");

   a_drive_steps_by_one: assert property (@(posedge clock) disable iff (reset)
      (fire && res_vld_ff) |=> (res_ff.drive_code == $past(res_ff.drive_code)
         || res_ff.drive_code == 8'($past(res_ff.drive_code) + 8'd1)
         || res_ff.drive_code == 8'($past(res_ff.drive_code) - 8'd1)))
      else $error("drive code moved by more than one step");

   a_calibrated_holds: assert property (@(posedge clock) disable iff (reset)
      (fire && res_vld_ff && res_ff.is_calibrated) |=> (res_ff.is_calibrated
         && !res_ff.drive_changed && res_ff.drive_code == $past(res_ff.drive_code)))
      else $error("state changed after calibration");
`endif

endmodule

`default_nettype wire
